FILE: src/mrrb_pkg.sv
// package for the multi-reader byte ring: sizes, request codes, register map
// and the transaction types of the request and response channels
// no dependencies
`timescale 1ns / 1ps

package mrrb_pkg;

   // ring geometry, depth is a power of two
   localparam int DEPTH_LOG2 = 18;
   localparam int DEPTH      = 1 << DEPTH_LOG2;
   localparam int PTR_W      = DEPTH_LOG2;

   // reader clients
   localparam int CLIENTS   = 3;
   localparam int CLIENT_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
   localparam int CNT_ADD_W = $clog2(CLIENTS + 1);

   // field widths
   localparam int DATA_W = 8;
   localparam int ID_W   = 3;
   localparam int FILL_W = 18;
   localparam int LAG_W  = 18;
   localparam int PCT_W  = 7;
   localparam int EVT_W  = 32;

   localparam int                 WIDE_W   = (PTR_W > FILL_W) ? PTR_W : FILL_W;
   localparam logic [WIDE_W-1:0]  FILL_MAX = WIDE_W'((64'd1 << FILL_W) - 64'd1);
   localparam int                 LIM_W    = PTR_W + PCT_W;
   localparam logic [LIM_W-1:0]   PCT_SCALE = LIM_W'(100);

   // register resets
   localparam logic [LAG_W-1:0] START_LAG_RESET = LAG_W'(144000);
   localparam logic [PCT_W-1:0] LOW_PCT_RESET   = PCT_W'(5);

   // apb register map
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic CSR_START_LAG = 1'b0;
   localparam logic CSR_LOW_PCT   = 1'b1;

   // request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_REG   = 2'd2;
   localparam logic [1:0] REQ_UNREG = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [DATA_W-1:0] write_data;
      logic              chunk_end;
      logic [ID_W-1:0]   reader_id;
   } req_item_type;

   typedef struct packed {
      logic              ok;
      logic              data_valid;
      logic [DATA_W-1:0] read_data;
      logic [FILL_W-1:0] fill_min;
      logic [EVT_W-1:0]  overrun_total;
   } rsp_item_type;

endpackage

FILE: src/mrrb_byte_ram.sv
// single-port-write, single-port-read synchronous ram for the ring bytes
// read data registered; no dependencies
`timescale 1ns / 1ps

module mrrb_byte_ram #(
   parameter int ADDR_W = 18,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/multi_reader_ring_buffer_top.sv
// top level of the multi-reader byte ring: request/response channels, apb
// register port, client pointer state and the byte memory
// depends on mrrb_pkg and mrrb_byte_ram
`timescale 1ns / 1ps
// an accepted transaction is registered in the pending slot together with
//   the byte memory read, then moves into the response register
// a new transaction is accepted only once the single pending slot has moved
//   into the response register, which may still hold a stalled response
// reset: synchronous, clears pointers, client flags, event count, channel
//   state and registers to their defaults; the byte store needs no clearing
//   pass, bytes never written since reset read as zero (write pointer + wrap)

module multi_reader_ring_buffer_top (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mrrb_pkg::req_item_type      req_data,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mrrb_pkg::rsp_item_type      rsp_data,
   // apb register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mrrb_pkg::PADDR_W-1:0] paddr,
   input  logic [mrrb_pkg::PDATA_W-1:0] pwdata,
   output logic [mrrb_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);

   import mrrb_pkg::*;

   // configuration registers
   logic [LAG_W-1:0] start_lag_ff, start_lag_in;
   logic [PCT_W-1:0] low_pct_ff, low_pct_in;

   // ring state
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic             wrapped_ff, wrapped_in;
   logic [PTR_W-1:0] rp_ff [CLIENTS];
   logic [PTR_W-1:0] rp_in [CLIENTS];
   logic [CLIENTS-1:0] active_ff, active_in;
   logic [EVT_W-1:0] evt_ff, evt_in;

   // pending slot between the memory read and the response register
   logic pend_valid_ff, pend_valid_in;
   logic pend_ok_ff, pend_ok_in;
   logic pend_dv_ff, pend_dv_in;
   logic pend_zero_ff, pend_zero_in;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   // memory access
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic                accept;
   logic                id_ok;
   logic [CLIENT_W-1:0] cidx;
   logic [PTR_W-1:0]    wp_inc;
   logic [PTR_W-1:0]    lag;
   logic [PTR_W-1:0]    rp_sel;
   logic [CNT_ADD_W-1:0] low_hits;
   logic [PTR_W-1:0]    fill_c;
   logic [LIM_W-1:0]    limit;
   logic                out_load;
   logic                csr_wr;
   logic                active_seen;
   logic [WIDE_W-1:0]   best;
   logic [WIDE_W-1:0]   fill_w;

   mrrb_byte_ram #(
      .ADDR_W (PTR_W),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_data.write_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // apb: always ready, write completes in the access phase
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      unique case (paddr[2])
         CSR_START_LAG: prdata = PDATA_W'(start_lag_ff);
         CSR_LOW_PCT:   prdata = PDATA_W'(low_pct_ff);
      endcase
   end

   always_comb begin
      start_lag_in = start_lag_ff;
      low_pct_in   = low_pct_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            CSR_START_LAG: start_lag_in = pwdata[LAG_W-1:0];
            CSR_LOW_PCT:   low_pct_in   = pwdata[PCT_W-1:0];
         endcase
      end
   end

   // one transaction in flight until it reaches the response register
   assign req_stall = pend_valid_ff;
   assign accept    = req_valid & ~pend_valid_ff;

   assign id_ok  = (int'(req_data.reader_id) < CLIENTS);
   assign cidx   = req_data.reader_id[CLIENT_W-1:0];
   assign wp_inc = wp_ff + PTR_W'(1);
   // start lag taken modulo the depth
   assign lag    = PTR_W'(start_lag_ff);
   assign limit  = {low_pct_ff, {PTR_W{1'b0}}};
   assign rp_sel = rp_ff[cidx];

   // low-fill check on chunk end, against the advanced write pointer
   always_comb begin
      low_hits = '0;
      fill_c   = '0;
      for (int c = 0; c < CLIENTS; c++) begin
         fill_c = wp_inc - rp_ff[c];
         if (active_ff[c] && (LIM_W'(fill_c) * PCT_SCALE < limit)) begin
            low_hits = low_hits + CNT_ADD_W'(1);
         end
      end
   end

   // state update at the accept edge, memory read issued for reads
   always_comb begin
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rp_in        = rp_ff;
      active_in    = active_ff;
      evt_in       = evt_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rp_sel;
      pend_ok_in   = pend_ok_ff;
      pend_dv_in   = pend_dv_ff;
      pend_zero_in = pend_zero_ff;

      if (accept) begin
         pend_ok_in   = 1'b0;
         pend_dv_in   = 1'b0;
         pend_zero_in = 1'b0;
         unique case (req_data.req_type)
            REQ_WRITE: begin
               ram_wr_en  = 1'b1;
               wp_in      = wp_inc;
               if (wp_inc == '0) begin
                  wrapped_in = 1'b1;
               end
               if (req_data.chunk_end) begin
                  evt_in = evt_ff + EVT_W'(low_hits);
               end
               pend_ok_in = 1'b1;
            end
            REQ_READ: begin
               if (id_ok && active_ff[cidx]) begin
                  pend_ok_in = 1'b1;
                  if (rp_sel != wp_ff) begin
                     ram_rd_en   = 1'b1;
                     pend_dv_in  = 1'b1;
                     // entry never written since reset reads as zero
                     pend_zero_in = ~wrapped_ff & (rp_sel >= wp_ff);
                     rp_in[cidx] = rp_sel + PTR_W'(1);
                  end
               end
            end
            REQ_REG: begin
               if (id_ok && !active_ff[cidx]) begin
                  rp_in[cidx]     = wp_ff - lag;
                  active_in[cidx] = 1'b1;
                  pend_ok_in      = 1'b1;
               end
            end
            REQ_UNREG: begin
               if (id_ok) begin
                  rp_in[cidx]     = '0;
                  active_in[cidx] = 1'b0;
                  pend_ok_in      = 1'b1;
               end
            end
         endcase
      end
   end

   // least fill over active clients, pointers are stable while pending
   always_comb begin
      active_seen = 1'b0;
      best        = '1;
      fill_w      = '0;
      for (int c = 0; c < CLIENTS; c++) begin
         fill_w = WIDE_W'(PTR_W'(wp_ff - rp_ff[c]));
         if (active_ff[c]) begin
            active_seen = 1'b1;
            if (fill_w < best) begin
               best = fill_w;
            end
         end
      end
      if (!active_seen) begin
         best = '0;
      end else if (best > FILL_MAX) begin
         best = FILL_MAX;
      end
   end

   // pending slot moves into the response register when it is free
   assign out_load = pend_valid_ff & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
      end else if (out_load) begin
         pend_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.ok             = pend_ok_ff;
         rsp_in.data_valid     = pend_dv_ff;
         rsp_in.read_data      = (pend_dv_ff && !pend_zero_ff) ? ram_rd_data : '0;
         rsp_in.fill_min       = FILL_W'(best);
         rsp_in.overrun_total  = evt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_lag_ff  <= START_LAG_RESET;
         low_pct_ff    <= LOW_PCT_RESET;
         wp_ff         <= '0;
         wrapped_ff    <= 1'b0;
         active_ff     <= '0;
         evt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < CLIENTS; c++) begin
            rp_ff[c] <= '0;
         end
      end else begin
         start_lag_ff  <= start_lag_in;
         low_pct_ff    <= low_pct_in;
         wp_ff         <= wp_in;
         wrapped_ff    <= wrapped_in;
         active_ff     <= active_in;
         evt_ff        <= evt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rp_ff         <= rp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ok_ff   <= pend_ok_in;
      pend_dv_ff   <= pend_dv_in;
      pend_zero_ff <= pend_zero_in;
      rsp_ff       <= rsp_in;
   end

endmodule
